[sv/ttcm_pkg.sv]
package ttcm_pkg;

  // Default converter resolution and the widest one the datapath supports.
  localparam int CODE_BITS_DEF = 12;
  localparam int CODE_MAX_BITS = 16;

  // Log unit: operand width, fraction bits and result width (5 integer bits).
  localparam int X_W    = 20;
  localparam int FRAC_W = 24;
  localparam int LOG_W  = 29;

  // ln 2 in Q.30.
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Temperature limits in 0.01 degC and the Celsius offset.
  localparam logic signed [15:0] TEMP_MIN   = -16'sd27315;
  localparam logic signed [15:0] TEMP_MAX   = 16'sd32767;
  localparam logic [15:0]        ZERO_C     = 16'd27315;
  localparam logic [15:0]        Q_SAT      = 16'd60082;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BETA    = 3'd0;
  localparam logic [2:0] CFG_NOMINAL = 3'd1;
  localparam logic [2:0] CFG_DIVIDER = 3'd2;
  localparam logic [2:0] CFG_REF     = 3'd3;
  localparam logic [2:0] CFG_RED     = 3'd4;
  localparam logic [2:0] CFG_GREEN   = 3'd5;
  localparam logic [2:0] CFG_BLUE    = 3'd6;

  // Register reset values.
  localparam logic [15:0] BETA_RST    = 16'd4100;
  localparam logic [19:0] NOMINAL_RST = 20'd10000;
  localparam logic [19:0] DIVIDER_RST = 20'd10000;
  localparam logic [15:0] REF_RST     = 16'd29815;
  localparam logic [31:0] RED_RST     = 32'd98304000;
  localparam logic [31:0] GREEN_RST   = 32'd196609000;
  localparam logic [31:0] BLUE_RST    = 32'd327684000;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOG   = 8'b00000010,
    S_SCALE = 8'b00000100,
    S_DENM  = 8'b00001000,
    S_DENA  = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  typedef struct packed {
    logic [11:0] therm_code;
    logic [11:0] knob_code;
    logic        toggle_press;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temp_centi_c;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
    logic [7:0]         blue_level;
    logic               red_in_window;
    logic               green_in_window;
    logic               blue_in_window;
    logic               lamp_on;
  } out_t;

  // Handshake between the sequencer and an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[sv/ttcm_log2.sv]
// Iterative log2 in unsigned Q.24: exact integer part, one fraction bit
// per cycle by squaring a Q1.30 mantissa.
module ttcm_log2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ttcm_pkg::X_W-1:0]    x,
  output ttcm_pkg::unit_stat_t        stat,
  output logic [ttcm_pkg::LOG_W-1:0]  result
);

  logic [4:0]                    e;
  logic [ttcm_pkg::X_W+29:0]     xs;
  logic [30:0]                   m;
  logic [61:0]                   sq;
  logic [31:0]                   t;
  logic [4:0]                    bit_idx;
  logic                          busy;
  logic                          done;

  // Position of the leading one.
  always_comb begin
    e = '0;
    for (int i = 0; i < ttcm_pkg::X_W; i++) begin
      if (x[i]) e = 5'(i);
    end
    xs = {x, 30'b0} >> e;
  end

  // Square the mantissa and take it back to Q1.30.
  assign sq = 62'(m) * 62'(m);
  assign t  = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bit_idx == 5'd0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_idx == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m       <= xs[30:0];
      result  <= {e, {ttcm_pkg::FRAC_W{1'b0}}};
      bit_idx <= 5'(ttcm_pkg::FRAC_W - 1);
    end else if (busy) begin
      if (t[31]) begin
        m               <= t[31:1];
        result[bit_idx] <= 1'b1;
      end else begin
        m <= t[30:0];
      end
      bit_idx <= bit_idx - 5'd1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/ttcm_div.sv]
// Restoring divider: one quotient bit per cycle for a 64-bit quotient.
module ttcm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [47:0]          divisor,
  output ttcm_pkg::unit_stat_t stat,
  output logic [63:0]          quotient
);

  logic [47:0] dsr;
  logic [47:0] rem;
  logic [48:0] rem_sh;
  logic [48:0] diff;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;

  assign rem_sh = {rem, quotient[63]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift in one dividend bit, subtract when the divisor fits.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr      <= divisor;
      rem      <= '0;
      quotient <= dividend;
      cnt      <= 7'd64;
    end else if (busy) begin
      if (!diff[48]) begin
        rem      <= diff[47:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= rem_sh[47:0];
        quotient <= {quotient[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/thermistor_temp_color_mixer_unit.sv]
// Thermistor temperature color mixer.
// Input channel in_valid/in_ready/in_data carries one beat per reading: a
// thermistor divider code, a knob code and a toggle flag. Output channel
// out_valid/out_ready/out_data returns one beat per reading: temperature in
// 0.01 degC, the red/green/blue levels, the three window flags and the lamp
// state. The config channel writes one register per beat by index and is
// always ready; write it only while the block is idle.
// From the accepting edge to the output register, one reading runs through
// a start step, four log2 evaluations in the shared squaring unit, four
// multiply, add and check steps, the bit-serial divider and a finish step.
// When the code or a resistor value is zero the Beta computation is
// skipped and the reading goes straight to the finish step; a non-positive
// Beta denominator ends the reading before the divider. in_ready is high
// only while the sequencer is idle, so a new reading is not accepted until
// the last one has been handed to the output register.
// The result sits in an output register; a new reading may be accepted
// while it waits. If the receiver stalls, the next result is held inside
// until the register frees up.
// Reset (rst, synchronous) restores the configuration registers to their
// defaults, turns the lamp on and clears the kept levels.
module thermistor_temp_color_mixer_unit #(
  parameter int CODE_BITS = ttcm_pkg::CODE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ttcm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ttcm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int CB = CODE_BITS;
  localparam logic [CB-1:0] FS = {CB{1'b1}};

  // Configuration registers.
  logic [15:0] beta_kelvin;
  logic [19:0] nominal_ohms;
  logic [19:0] divider_ohms;
  logic [15:0] ref_centikelvin;
  logic [31:0] red_window;
  logic [31:0] green_window;
  logic [31:0] blue_window;

  ttcm_pkg::state_t state;

  logic [CB-1:0]  code;
  logic [CB-1:0]  knob;
  logic [CB-1:0]  dcode;
  logic [CB+11:0] d_scaled;
  logic           floor_hit;
  logic           zero_case;
  logic [CB+7:0]  y;
  logic [CB+8:0]  yy;
  logic [8:0]     q0;
  logic [CB+8:0]  r0;

  logic                 toggle;
  logic [15:0]          nr;
  logic [15:0]          dr;
  logic [1:0]           k;
  logic signed [31:0]   s_acc;
  logic [29:0]          mag;
  logic [59:0]          lnprod;
  logic [59:0]          lnround;
  logic signed [30:0]   lns;
  logic [31:0]          rb;
  logic signed [47:0]   rl;
  logic [22:0]          beta100;
  logic signed [48:0]   den;
  logic [62:0]          num;
  logic [63:0]          dividend;
  logic signed [15:0]   temp;
  logic [16:0]          temp_wide;
  logic [8:0]           duty_q;
  logic [CB+8:0]        duty_r;
  logic                 duty_ok;

  logic                         log_start;
  logic [ttcm_pkg::X_W-1:0]     log_x;
  ttcm_pkg::unit_stat_t         log_stat;
  logic [ttcm_pkg::LOG_W-1:0]   log_res;
  logic                         div_start;
  ttcm_pkg::unit_stat_t         div_stat;
  logic [63:0]                  div_q;

  logic       in_fire;
  logic       fin_fire;
  logic       lamp_state;
  logic       lamp_next;
  logic [7:0] kept_red;
  logic [7:0] kept_green;
  logic [7:0] kept_blue;
  logic       win_r;
  logic       win_g;
  logic       win_b;
  logic [7:0] lvl_r;
  logic [7:0] lvl_g;
  logic [7:0] lvl_b;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ttcm_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_kelvin     <= ttcm_pkg::BETA_RST;
      nominal_ohms    <= ttcm_pkg::NOMINAL_RST;
      divider_ohms    <= ttcm_pkg::DIVIDER_RST;
      ref_centikelvin <= ttcm_pkg::REF_RST;
      red_window      <= ttcm_pkg::RED_RST;
      green_window    <= ttcm_pkg::GREEN_RST;
      blue_window     <= ttcm_pkg::BLUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttcm_pkg::CFG_BETA:    beta_kelvin     <= cfg_data[15:0];
        ttcm_pkg::CFG_NOMINAL: nominal_ohms    <= cfg_data[19:0];
        ttcm_pkg::CFG_DIVIDER: divider_ohms    <= cfg_data[19:0];
        ttcm_pkg::CFG_REF:     ref_centikelvin <= cfg_data[15:0];
        ttcm_pkg::CFG_RED:     red_window      <= cfg_data;
        ttcm_pkg::CFG_GREEN:   green_window    <= cfg_data;
        ttcm_pkg::CFG_BLUE:    blue_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input decode: codes trimmed to the converter width, ratio floor near
  // full scale, and a first estimate of the brightness division by FS.
  always_comb begin
    code      = CB'({4'b0, in_data.therm_code});
    knob      = CB'({4'b0, in_data.knob_code});
    dcode     = FS - code;
    d_scaled  = (CB+12)'(dcode) * (CB+12)'(3300);
    floor_hit = d_scaled < (CB+12)'(FS);
    y         = {knob, 8'b0} - (CB+8)'(knob);
    yy        = (CB+9)'(y) + (CB+9)'(y >> CB);
    q0        = yy[CB+8:CB];
    r0        = (CB+9)'(y) - ((CB+9)'(q0) << CB) + (CB+9)'(q0);
  end

  // A zero code or resistor value skips the whole Beta computation.
  assign zero_case = (code == '0) || (divider_ohms == '0) || (nominal_ohms == '0);

  assign duty_ok = duty_r < (CB+9)'(FS);

  // Operand for the shared log unit, in the order the sum is built.
  always_comb begin
    unique case (k)
      2'd0:    log_x = divider_ohms;
      2'd1:    log_x = ttcm_pkg::X_W'(nr);
      2'd2:    log_x = ttcm_pkg::X_W'(dr);
      default: log_x = nominal_ohms;
    endcase
  end

  ttcm_log2 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .stat   (log_stat),
    .result (log_res)
  );

  ttcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den[47:0]),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Beta model arithmetic.
  assign mag       = s_acc[31] ? 30'(-s_acc) : 30'(s_acc);
  assign lnprod    = 60'(mag) * 60'(ttcm_pkg::LN2_Q30);
  assign lnround   = lnprod + 60'(1 << 29);
  assign beta100   = 23'(beta_kelvin) * 23'd100;
  assign dividend  = 64'(num) + 64'(den[47:1]);
  assign temp_wide = {1'b0, div_q[15:0]} - {1'b0, ttcm_pkg::ZERO_C};

  // Window tests and level gating.
  always_comb begin
    win_r = (temp >= $signed(red_window[15:0]))   && (temp <= $signed(red_window[31:16]));
    win_g = (temp >= $signed(green_window[15:0])) && (temp <= $signed(green_window[31:16]));
    win_b = (temp >= $signed(blue_window[15:0]))  && (temp <= $signed(blue_window[31:16]));
    lamp_next = toggle ? !lamp_state : lamp_state;
    lvl_r = 8'b0;
    lvl_g = 8'b0;
    lvl_b = 8'b0;
    if (toggle) begin
      if (lamp_next) begin
        lvl_r = kept_red;
        lvl_g = kept_green;
        lvl_b = kept_blue;
      end
    end else if (lamp_state) begin
      lvl_r = win_r ? duty_q[7:0] : 8'b0;
      lvl_g = win_g ? duty_q[7:0] : 8'b0;
      lvl_b = win_b ? duty_q[7:0] : 8'b0;
    end
  end

  assign fin_fire = (state == ttcm_pkg::S_FIN) && duty_ok && (!out_valid || out_ready);

  // Start pulses for the shared units, raised in the cycle after the sequencer asks.
  always_ff @(posedge clk) begin
    if (rst) begin
      log_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      log_start <= (in_fire && !zero_case)
                || ((state == ttcm_pkg::S_LOG) && log_stat.done && (k != 2'd3));
      div_start <= (state == ttcm_pkg::S_CHK) && (den > 49'sd0);
    end
  end

  // Output valid: set when a result is handed over, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttcm_pkg::S_IDLE;
      lamp_state <= 1'b1;
      kept_red   <= 8'b0;
      kept_green <= 8'b0;
      kept_blue  <= 8'b0;
    end else begin
      unique case (state)
        ttcm_pkg::S_IDLE: begin
          if (in_fire) begin
            if (zero_case) begin
              state <= ttcm_pkg::S_FIN;
            end else begin
              state <= ttcm_pkg::S_LOG;
            end
          end
        end
        ttcm_pkg::S_LOG: begin
          if (log_stat.done && k == 2'd3) state <= ttcm_pkg::S_SCALE;
        end
        ttcm_pkg::S_SCALE: state <= ttcm_pkg::S_DENM;
        ttcm_pkg::S_DENM:  state <= ttcm_pkg::S_DENA;
        ttcm_pkg::S_DENA:  state <= ttcm_pkg::S_CHK;
        ttcm_pkg::S_CHK: begin
          if (den <= 49'sd0) begin
            state <= ttcm_pkg::S_FIN;
          end else begin
            state <= ttcm_pkg::S_DIV;
          end
        end
        ttcm_pkg::S_DIV: begin
          if (div_stat.done) state <= ttcm_pkg::S_FIN;
        end
        ttcm_pkg::S_FIN: begin
          if (fin_fire) begin
            state      <= ttcm_pkg::S_IDLE;
            lamp_state <= lamp_next;
            if (toggle && !lamp_next) begin
              kept_red   <= win_r ? duty_q[7:0] : 8'b0;
              kept_green <= win_g ? duty_q[7:0] : 8'b0;
              kept_blue  <= win_b ? duty_q[7:0] : 8'b0;
            end
          end
        end
        default: state <= ttcm_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      toggle <= in_data.toggle_press;
      nr     <= floor_hit ? 16'd3299 : 16'(code);
      dr     <= floor_hit ? 16'd1 : 16'(dcode);
      k      <= 2'd0;
      s_acc  <= '0;
      temp   <= ttcm_pkg::TEMP_MIN;
      duty_q <= q0;
      duty_r <= r0;
    end else begin
      // Brightness correction steps run alongside the main sequence.
      if (!duty_ok) begin
        duty_q <= duty_q + 9'd1;
        duty_r <= duty_r - (CB+9)'(FS);
      end
      if (state == ttcm_pkg::S_LOG && log_stat.done) begin
        if (k == 2'd0 || k == 2'd1) begin
          s_acc <= s_acc + 32'(log_res);
        end else begin
          s_acc <= s_acc - 32'(log_res);
        end
        k <= k + 2'd1;
      end
      if (state == ttcm_pkg::S_SCALE) begin
        lns <= s_acc[31] ? -$signed({1'b0, lnround[59:30]})
                         : $signed({1'b0, lnround[59:30]});
        rb  <= 32'(ref_centikelvin) * 32'(beta_kelvin);
      end
      if (state == ttcm_pkg::S_DENM) begin
        rl  <= $signed({1'b0, ref_centikelvin}) * lns;
        num <= {39'(rb) * 39'd100, 24'b0};
      end
      if (state == ttcm_pkg::S_DENA) begin
        den <= $signed({2'b0, beta100, 24'b0}) + 49'(rl);
      end
      if (state == ttcm_pkg::S_DIV && div_stat.done) begin
        temp <= (div_q > 64'(ttcm_pkg::Q_SAT)) ? ttcm_pkg::TEMP_MAX
                                               : $signed(temp_wide[15:0]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data.temp_centi_c    <= temp;
      out_data.red_level       <= lvl_r;
      out_data.green_level     <= lvl_g;
      out_data.blue_level      <= lvl_b;
      out_data.red_in_window   <= win_r;
      out_data.green_in_window <= win_g;
      out_data.blue_in_window  <= win_b;
      out_data.lamp_on         <= lamp_next;
    end
  end

  // The sequencer is busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while a reading was in progress");

  // Unit completions only arrive in the state waiting for them.
  a_log_done_state: assert property (@(posedge clk) disable iff (rst)
    log_stat.done |-> state == ttcm_pkg::S_LOG)
    else $error("log unit finished outside the log phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ttcm_pkg::S_DIV)
    else $error("divider finished outside the divide phase");

  // The lamp only flips when a toggled result is handed out.
  a_lamp_flip: assert property (@(posedge clk) disable iff (rst)
    (lamp_state != $past(lamp_state)) |-> $past(fin_fire && toggle))
    else $error("lamp state changed without a toggle");

endmodule
